// File: rtl/lrp_pkg.sv
// Shared constants, types and decode tables for the location report parser.
`default_nettype none
package lrp_pkg;

  localparam int unsigned MAX_PDU_BYTES = 32;
  localparam int unsigned PTR_W = $clog2(MAX_PDU_BYTES);
  localparam int unsigned CNT_W = $clog2(MAX_PDU_BYTES + 1);
  localparam int unsigned POS_W = CNT_W + 3;

  localparam logic [1:0] STATUS_SHORT  = 2'd0;
  localparam logic [1:0] STATUS_LONG   = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  localparam logic [3:0] SHAPE_LAST = 4'd10;
  localparam logic [3:0] TYPE_EXT_LOC = 4'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [23:0] lat;
    logic [24:0] lon;
    logic        alt_en;
    logic [10:0] alt_code;
    logic [6:0]  spd_code;
    logic [7:0]  dir;
    logic [7:0]  reason;
    logic [31:0] fix_time;
  } lrp_rec_t;

  typedef logic [15:0] speed_rom_t [128];

  function automatic logic [15:0] speed_q6_f(input int unsigned n);
    logic [63:0] p;
    logic [63:0] r;
    begin
      p = 64'd1 << 56;
      if (n <= 28) begin
        r = (64'(n) * 64'd64000 + 64'd926) / 64'd1852;
      end else if (n == 127) begin
        r = 64'd0;
      end else begin
        for (int unsigned k = 13; k < n; k++) begin
          p = p + (p / 64'd1000) * 64'd38 + ((p % 64'd1000) * 64'd38 + 64'd500) / 64'd1000;
        end
        r = ((p >> 16) * 64'd1024 + 64'd926) / 64'd1852;
        r = (r + (64'd1 << 39)) >> 40;
      end
      return r[15:0];
    end
  endfunction

  function automatic speed_rom_t build_speed_rom();
    speed_rom_t t;
    begin
      for (int unsigned i = 0; i < 128; i++) begin
        t[i] = speed_q6_f(i);
      end
      return t;
    end
  endfunction

  localparam speed_rom_t SPEED_ROM = build_speed_rom();

  function automatic logic [5:0] shape_pre(input logic [3:0] s);
    case (s)
      4'd2, 4'd5, 4'd7: return 6'd6;
      4'd3:             return 6'd23;
      4'd6, 4'd8:       return 6'd20;
      4'd9:             return 6'd51;
      default:          return 6'd0;
    endcase
  endfunction

  function automatic logic shape_alt(input logic [3:0] s);
    case (s)
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: return 1'b1;
      default:                      return 1'b0;
    endcase
  endfunction

  function automatic logic [2:0] shape_post(input logic [3:0] s);
    case (s)
      4'd6, 4'd7: return 3'd3;
      4'd8:       return 3'd6;
      default:    return 3'd0;
    endcase
  endfunction

  function automatic logic [3:0] vel_pre(input logic [2:0] v);
    case (v)
      3'd2, 3'd6: return 4'd3;
      3'd3:       return 4'd8;
      3'd4, 3'd7: return 4'd14;
      default:    return 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] vel_post(input logic [2:0] v);
    case (v)
      3'd6, 3'd7: return 2'd3;
      default:    return 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/lrp_out_stage.sv
// Result register: speed ROM lookup, altitude decode and output handshake.
`default_nettype none
module lrp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire lrp_pkg::lrp_rec_t  rec,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic                    out_position_valid,
  output logic signed [23:0]      out_latitude_raw,
  output logic signed [24:0]      out_longitude_raw,
  output logic signed [14:0]      out_altitude_m,
  output logic [15:0]             out_speed_knots_q6,
  output logic [7:0]              out_heading_256,
  output logic [7:0]              out_reason_code,
  output logic [31:0]             out_fix_time
);
  import lrp_pkg::*;

  logic               valid_r;
  logic signed [18:0] alt_code_s;
  logic signed [18:0] alt_full;
  logic               rej;

  assign rej        = (rec.status == STATUS_REJECT);
  assign alt_code_s = {8'b0, rec.alt_code};

  always_comb begin
    if (!rec.alt_en || rec.alt_code == 11'd0) begin
      alt_full = '0;
    end else if (rec.alt_code <= 11'd1200) begin
      alt_full = alt_code_s - 19'sd201;
    end else if (rec.alt_code <= 11'd1926) begin
      alt_full = (alt_code_s <<< 1) - 19'sd1402;
    end else begin
      alt_full = alt_code_s * 19'sd75 - 19'sd142000;
    end
  end

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (load) begin
      out_status         <= rec.status;
      out_position_valid <= rej ? 1'b0 : rec.valid;
      out_latitude_raw   <= rej ? '0 : rec.lat;
      out_longitude_raw  <= rej ? '0 : rec.lon;
      out_altitude_m     <= rej ? '0 : alt_full[14:0];
      out_speed_knots_q6 <= rej ? '0 : SPEED_ROM[rec.spd_code];
      out_heading_256    <= rej ? '0 : rec.dir;
      out_reason_code    <= rej ? '0 : rec.reason;
      out_fix_time       <= rej ? '0 : rec.fix_time;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n) load |-> free)
    else $error("result loaded while previous one still stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall && !load) |=> valid_r)
    else $error("stalled result dropped");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && !load) |=> !valid_r)
    else $error("result repeated");
`endif

endmodule
`default_nettype wire

// File: rtl/location_report_pdu_parser.sv
// Top level: PDU byte store and bit-serial location report field parser.
//
//  channel | ports                                   | accepted when
//  in      | in_pdu_byte, in_last_byte, in_receive_time | in_valid && !in_stall
//  out     | out_status ... out_fix_time             | out_valid && !out_stall
//
// A non-final byte is accepted whenever the parser is idle. On the final byte the
// stored PDU is walked one bit per cycle, with a decode step after each field, by
// the serial bit reader on the single byte store read port. in_stall is high while
// parsing and while the result waits for the result register. Reset clears the
// byte count and all control; stored bytes stay undefined until written.
`default_nettype none
module location_report_pdu_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_pdu_byte,
  input  wire logic         in_last_byte,
  input  wire logic [31:0]  in_receive_time,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        out_status,
  output logic              out_position_valid,
  output logic signed [23:0] out_latitude_raw,
  output logic signed [24:0] out_longitude_raw,
  output logic signed [14:0] out_altitude_m,
  output logic [15:0]       out_speed_knots_q6,
  output logic [7:0]        out_heading_256,
  output logic [7:0]        out_reason_code,
  output logic [31:0]       out_fix_time
);
  import lrp_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_READ, ST_DONE} state_t;
  typedef enum logic [4:0] {
    F_TYPE, F_SPAD, F_LON, F_LAT, F_ERR, F_SPD, F_DIR4, F_RFLAG, F_REASON,
    F_EXT, F_TT, F_TSKIP, F_SHAPE, F_SPRE, F_ALT, F_SPOST, F_PERR, F_VEL,
    F_LSPD, F_VPRE, F_LDIR, F_VPOST, F_SPARE
  } field_t;

  logic [7:0] mem [MAX_PDU_BYTES];
  logic [7:0] mem_q_r;

  state_t           state_r, state_nxt;
  field_t           field_r, field_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [24:0]      acc_r, acc_nxt;
  logic [POS_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0] rd_len_r, rd_len_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             long_r, long_nxt;
  logic [3:0]       shape_r, shape_nxt;
  logic [2:0]       vel_r, vel_nxt;
  lrp_rec_t         rec_r, rec_nxt;

  logic in_acc, store_en, bit_in, out_free, load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign store_en = in_acc && (byte_count_r < CNT_W'(MAX_PDU_BYTES));
  assign load     = (state_r == ST_DONE) && out_free;
  assign bit_in   = (rd_pos_r[POS_W-1:3] < rd_len_r) ? mem_q_r[~rd_pos_r[2:0]] : 1'b0;

  always_comb begin
    state_nxt      = state_r;
    field_nxt      = field_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    rd_pos_nxt     = rd_pos_r;
    rd_len_nxt     = rd_len_r;
    byte_count_nxt = byte_count_r;
    long_nxt       = long_r;
    shape_nxt      = shape_r;
    vel_nxt        = vel_r;
    rec_nxt        = rec_r;
    case (state_r)
      ST_IDLE: begin
        rd_pos_nxt = '0;
        if (in_acc) begin
          if (store_en) byte_count_nxt = byte_count_r + 1'b1;
          if (in_last_byte) begin
            rd_len_nxt       = store_en ? byte_count_r + 1'b1 : byte_count_r;
            byte_count_nxt   = '0;
            state_nxt        = ST_LOAD;
            field_nxt        = F_TYPE;
            cnt_nxt          = 6'd2;
            acc_nxt          = '0;
            long_nxt         = 1'b0;
            rec_nxt          = '0;
            rec_nxt.status   = STATUS_REJECT;
            rec_nxt.fix_time = in_receive_time;
          end
        end
      end
      ST_LOAD: state_nxt = ST_READ;
      ST_READ: begin
        if (cnt_r != 6'd0) begin
          acc_nxt    = {acc_r[23:0], bit_in};
          cnt_nxt    = cnt_r - 1'b1;
          rd_pos_nxt = rd_pos_r + 1'b1;
        end else begin
          acc_nxt = '0;
          case (field_r)
            F_TYPE: begin
              if (acc_r[1:0] == 2'd0) begin
                rec_nxt.status = STATUS_SHORT;
                field_nxt = F_SPAD; cnt_nxt = 6'd2;
              end else if (acc_r[1:0] == 2'd1) begin
                field_nxt = F_EXT; cnt_nxt = 6'd4;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            F_SPAD:  begin field_nxt = F_LON; cnt_nxt = 6'd25; end
            F_LON:   begin rec_nxt.lon = acc_r; field_nxt = F_LAT; cnt_nxt = 6'd24; end
            F_LAT: begin
              rec_nxt.lat = acc_r[23:0];
              if (long_r) begin
                field_nxt = F_SPRE; cnt_nxt = shape_pre(shape_r);
              end else begin
                field_nxt = F_ERR; cnt_nxt = 6'd3;
              end
            end
            F_ERR: begin
              rec_nxt.valid = ((rec_r.lat != '0) || (rec_r.lon != '0)) && (acc_r[2:0] != 3'd7);
              field_nxt = F_SPD; cnt_nxt = 6'd7;
            end
            F_SPD:   begin rec_nxt.spd_code = acc_r[6:0]; field_nxt = F_DIR4; cnt_nxt = 6'd4; end
            F_DIR4:  begin rec_nxt.dir = {acc_r[3:0], 4'b0}; field_nxt = F_RFLAG; cnt_nxt = 6'd1; end
            F_RFLAG: begin
              if (acc_r[0] == 1'b0) begin
                field_nxt = F_REASON; cnt_nxt = 6'd8;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            F_REASON: begin rec_nxt.reason = acc_r[7:0]; state_nxt = ST_DONE; end
            F_EXT: begin
              if (acc_r[3:0] == TYPE_EXT_LOC) begin
                field_nxt = F_TT; cnt_nxt = 6'd2;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            F_TT: begin
              field_nxt = F_TSKIP;
              case (acc_r[1:0])
                2'd1:    cnt_nxt = 6'd2;
                2'd2:    cnt_nxt = 6'd22;
                2'd3:    state_nxt = ST_DONE;
                default: cnt_nxt = 6'd0;
              endcase
            end
            F_TSKIP: begin field_nxt = F_SHAPE; cnt_nxt = 6'd4; end
            F_SHAPE: begin
              if (acc_r[3:0] > SHAPE_LAST) begin
                state_nxt = ST_DONE;
              end else begin
                rec_nxt.status = STATUS_LONG;
                shape_nxt = acc_r[3:0];
                long_nxt  = 1'b1;
                if (acc_r[3:0] == 4'd0) begin
                  rec_nxt.valid = 1'b0;
                  field_nxt = F_VEL; cnt_nxt = 6'd3;
                end else begin
                  rec_nxt.valid = 1'b1;
                  field_nxt = F_LON; cnt_nxt = 6'd25;
                end
              end
            end
            F_SPRE: begin
              if (shape_alt(shape_r)) begin
                field_nxt = F_ALT; cnt_nxt = 6'd12;
              end else begin
                field_nxt = F_SPOST; cnt_nxt = 6'(shape_post(shape_r));
              end
            end
            F_ALT: begin
              rec_nxt.alt_en = 1'b1;
              rec_nxt.alt_code = acc_r[10:0];
              field_nxt = F_SPOST; cnt_nxt = 6'(shape_post(shape_r));
            end
            F_SPOST: begin
              cnt_nxt   = 6'd3;
              field_nxt = (shape_r == SHAPE_LAST) ? F_PERR : F_VEL;
            end
            F_PERR: begin
              if (acc_r[2:0] == 3'd7) rec_nxt.valid = 1'b0;
              field_nxt = F_VEL; cnt_nxt = 6'd3;
            end
            F_VEL: begin
              vel_nxt = acc_r[2:0];
              if (acc_r[2:0] != 3'd0) begin
                field_nxt = F_LSPD; cnt_nxt = 6'd7;
              end else begin
                field_nxt = F_VPRE; cnt_nxt = 6'(vel_pre(acc_r[2:0]));
              end
            end
            F_LSPD: begin
              rec_nxt.spd_code = acc_r[6:0];
              field_nxt = F_VPRE; cnt_nxt = 6'(vel_pre(vel_r));
            end
            F_VPRE: begin
              if (vel_r >= 3'd5) begin
                field_nxt = F_LDIR; cnt_nxt = 6'd8;
              end else begin
                field_nxt = F_VPOST; cnt_nxt = 6'(vel_post(vel_r));
              end
            end
            F_LDIR: begin
              rec_nxt.dir = acc_r[7:0];
              field_nxt = F_VPOST; cnt_nxt = 6'(vel_post(vel_r));
            end
            F_VPOST: begin field_nxt = F_SPARE; cnt_nxt = 6'd1; end
            F_SPARE: begin field_nxt = F_RFLAG; cnt_nxt = 6'd1; end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      byte_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
    end
    field_r  <= field_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    rd_pos_r <= rd_pos_nxt;
    rd_len_r <= rd_len_nxt;
    long_r   <= long_nxt;
    shape_r  <= shape_nxt;
    vel_r    <= vel_nxt;
    rec_r    <= rec_nxt;
  end

  // byte store: one write port, one registered read port following rd_pos
  always_ff @(posedge clk) begin
    if (store_en) mem[byte_count_r[PTR_W-1:0]] <= in_pdu_byte;
    mem_q_r <= mem[rd_pos_nxt[PTR_W+2:3]];
  end

  lrp_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .rec                (rec_r),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_position_valid (out_position_valid),
    .out_latitude_raw   (out_latitude_raw),
    .out_longitude_raw  (out_longitude_raw),
    .out_altitude_m     (out_altitude_m),
    .out_speed_knots_q6 (out_speed_knots_q6),
    .out_heading_256    (out_heading_256),
    .out_reason_code    (out_reason_code),
    .out_fix_time       (out_fix_time)
  );

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CNT_W'(MAX_PDU_BYTES))
    else $error("byte count past store depth");
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (state_r == ST_LOAD && byte_count_r == '0))
    else $error("final byte did not start parse");
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rd_len_r != '0))
    else $error("parsing an empty PDU");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid)
    else $error("finished parse produced no result");
`endif

endmodule
`default_nettype wire

// File: tb/sv/location_report_pdu_parser_checker.sv
// Checker: watches both channels, decodes each PDU on its last byte and compares results.
module location_report_pdu_parser_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_pdu_byte,
  input  logic              in_last_byte,
  input  logic [31:0]       in_receive_time,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic              out_position_valid,
  input  logic [23:0]       out_latitude_raw,
  input  logic [24:0]       out_longitude_raw,
  input  logic [14:0]       out_altitude_m,
  input  logic [15:0]       out_speed_knots_q6,
  input  logic [7:0]        out_heading_256,
  input  logic [7:0]        out_reason_code,
  input  logic [31:0]       out_fix_time,
  output int                fail_count,
  output int                pending_reports
);
  import lrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [23:0] lat;
    logic [24:0] lon;
    logic [14:0] alt;
    logic [15:0] spd;
    logic [7:0]  dir;
    logic [7:0]  reason;
    logic [31:0] fix_time;
  } report_t;

  logic [7:0] pdu_bytes [MAX_PDU_BYTES];
  int unsigned pdu_len;
  int unsigned read_len;
  int unsigned bit_pos;
  report_t expected_reports[$];

  assign pending_reports = expected_reports.size();

  function automatic logic [31:0] pull_bits(int unsigned n);
    logic [31:0] v;
    int unsigned idx;
    logic b;
    v = '0;
    for (int unsigned i = 0; i < n; i++) begin
      idx = bit_pos >> 3;
      b = 1'b0;
      if (idx < read_len && idx < MAX_PDU_BYTES) b = pdu_bytes[idx][7 - (bit_pos & 7)];
      v = {v[30:0], b};
      bit_pos++;
    end
    return v;
  endfunction

  function automatic logic [15:0] knots_q6(logic [6:0] n);
    logic [63:0] p;
    logic [63:0] r;
    p = 64'd1 << 56;
    if (n <= 28) return 16'((64'(n) * 64'd64000 + 64'd926) / 64'd1852);
    if (n == 7'd127) return 16'd0;
    for (int k = 13; k < n; k++)
      p = p + (p / 64'd1000) * 64'd38 + ((p % 64'd1000) * 64'd38 + 64'd500) / 64'd1000;
    r = ((p >> 16) * 64'd1024 + 64'd926) / 64'd1852;
    return 16'((r + (64'd1 << 39)) >> 40);
  endfunction

  function automatic logic [14:0] altitude_m(logic [10:0] a);
    int v;
    if (a == 0) v = 0;
    else if (a <= 1200) v = int'(a) - 201;
    else if (a <= 1926) v = int'(a) * 2 - 1402;
    else v = int'(a) * 75 - 142000;
    return 15'(v);
  endfunction

  function automatic report_t decode_report(logic [31:0] rx_time);
    report_t r;
    logic [7:0] b0;
    logic [31:0] err, tt, shape, vel, spd_code;
    logic [3:0] sh;
    logic [2:0] vc;
    r = '0;
    r.status = STATUS_REJECT;
    bit_pos = 0;
    b0 = pdu_bytes[0];
    if (b0[7:6] == 2'b00) begin
      bit_pos = 4;
      r.lon = 25'(pull_bits(25));
      r.lat = 24'(pull_bits(24));
      err = pull_bits(3);
      r.spd = knots_q6(7'(pull_bits(7)));
      r.dir = 8'(pull_bits(4) * 16);
      r.reason = pull_bits(1) == 0 ? 8'(pull_bits(8)) : 8'd0;
      r.valid = (r.lat != 0 || r.lon != 0) && err != 7;
      r.status = STATUS_SHORT;
      r.fix_time = rx_time;
    end else if (b0[7:6] == 2'b01 && b0[5:2] == TYPE_EXT_LOC) begin
      bit_pos = 6;
      tt = pull_bits(2);
      if (tt == 1) void'(pull_bits(2));
      else if (tt == 2) void'(pull_bits(22));
      if (tt != 3) begin
        shape = pull_bits(4);
        if (shape <= SHAPE_LAST) begin
          sh = shape[3:0];
          r.valid = 1'b1;
          if (sh != 0) begin
            r.lon = 25'(pull_bits(25));
            r.lat = 24'(pull_bits(24));
            case (sh)
              2, 5, 7: void'(pull_bits(6));
              3: void'(pull_bits(23));
              6, 8: void'(pull_bits(20));
              9: void'(pull_bits(51));
              default: ;
            endcase
            if (sh >= 4 && sh <= 8) r.alt = altitude_m(11'(pull_bits(12)));
            if (sh == 6 || sh == 7) void'(pull_bits(3));
            if (sh == 8) void'(pull_bits(6));
            if (sh == SHAPE_LAST && pull_bits(3) == 7) r.valid = 1'b0;
          end else begin
            r.valid = 1'b0;
          end
          vel = pull_bits(3);
          vc = vel[2:0];
          spd_code = 0;
          if (vc != 0) spd_code = pull_bits(7);
          case (vc)
            2, 6: void'(pull_bits(3));
            3: void'(pull_bits(8));
            4, 7: void'(pull_bits(14));
            default: ;
          endcase
          if (vc >= 5) r.dir = 8'(pull_bits(8));
          if (vc >= 6) void'(pull_bits(3));
          r.spd = knots_q6(spd_code[6:0]);
          void'(pull_bits(1));
          r.reason = pull_bits(1) == 0 ? 8'(pull_bits(8)) : 8'd0;
          r.status = STATUS_LONG;
          r.fix_time = rx_time;
        end
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    report_t e;
    if (!rst_n) begin
      pdu_len = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (pdu_len < MAX_PDU_BYTES) begin
          pdu_bytes[pdu_len] = in_pdu_byte;
          pdu_len++;
        end
        if (in_last_byte) begin
          read_len = pdu_len;
          pdu_len = 0;
          expected_reports.push_back(decode_report(in_receive_time));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result transaction, status %0d", $time, out_status);
        end else begin
          e = expected_reports.pop_front();
          compare_field("status", e.status, out_status);
          compare_field("position_valid", e.valid, out_position_valid);
          compare_field("latitude_raw", e.lat, out_latitude_raw);
          compare_field("longitude_raw", e.lon, out_longitude_raw);
          compare_field("altitude_m", e.alt, out_altitude_m);
          compare_field("speed_knots_q6", e.spd, out_speed_knots_q6);
          compare_field("heading_256", e.dir, out_heading_256);
          compare_field("reason_code", e.reason, out_reason_code);
          compare_field("fix_time", e.fix_time, out_fix_time);
        end
      end
    end
  end
endmodule

// File: tb/sv/location_report_pdu_parser_tb.sv
// Testbench top: drives location PDUs with random gaps and stalls, reports the verdict.
module location_report_pdu_parser_tb;
  import lrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_pdu_byte = '0;
  logic in_last_byte = 1'b0;
  logic [31:0] in_receive_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_position_valid;
  logic signed [23:0] out_latitude_raw;
  logic signed [24:0] out_longitude_raw;
  logic signed [14:0] out_altitude_m;
  logic [15:0] out_speed_knots_q6;
  logic [7:0] out_heading_256;
  logic [7:0] out_reason_code;
  logic [31:0] out_fix_time;
  int fail_count;
  int pending_reports;
  int idle_cycles = 0;
  int bytes_sent = 0;
  bit hold_done = 0;
  bit stimulus_done = 0;

  location_report_pdu_parser dut (.*);

  location_report_pdu_parser_checker checker_i (.*);

  initial forever #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // Called at a falling edge; valid stays up between back-to-back bytes.
  task automatic send_byte(logic [7:0] b, logic last);
    int g;
    g = gap_len();
    if ($urandom_range(0, 3) != 0) g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pdu_byte <= b;
    in_last_byte <= last;
    in_receive_time <= $urandom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Bit-packs a PDU MSB first and sends it, n bytes long.
  task automatic send_pdu(logic [255:0] bits, int n);
    for (int i = 0; i < n; i++) send_byte(bits[255 - 8 * i -: 8], i == n - 1);
  endtask

  function automatic logic [255:0] long_pdu(logic [1:0] tt, logic [3:0] shape, logic [2:0] vel);
    logic [255:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    v[255:248] = {2'b01, TYPE_EXT_LOC, tt};
    case (tt)
      2'd0: v[247:244] = shape;
      2'd1: v[245:242] = shape;
      default: v[223:220] = shape;
    endcase
    // velocity code sits after a shape-dependent run; it is placed here only for shape 0
    if (shape == 0) begin
      case (tt)
        2'd0: v[243:241] = vel;
        2'd1: v[241:239] = vel;
        default: v[219:217] = vel;
      endcase
    end
    return v;
  endfunction

  task automatic random_pdu();
    logic [255:0] v;
    int n;
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      v = long_pdu(2'($urandom_range(0, 2)), 4'($urandom_range(0, 10)), 3'($urandom));
      n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 36) : $urandom_range(8, 20);
    end else if (k < 9) begin
      v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      v[255:254] = 2'b00;
      n = $urandom_range(0, 7) == 0 ? $urandom_range(1, 36) : $urandom_range(8, 10);
    end else begin
      v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      n = $urandom_range(1, 36);
    end
    if (n > 32) begin
      for (int i = 0; i < 32; i++) send_byte(v[255 - 8 * i -: 8], 1'b0);
      repeat (n - 32) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end else begin
      send_pdu(v, n);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: short extremes, rejects, time types, every shape and velocity code
    send_pdu('0, 11);
    send_pdu({4'h0, 25'h1ffffff, 24'hffffff, 3'd7, 7'd127, 4'hf, 1'b0, 8'hff, 180'd0}, 11);
    send_pdu({4'h0, 25'h1000000, 24'h800000, 3'd0, 7'd28, 4'h1, 1'b1, 8'h00, 180'd0}, 11);
    send_pdu({4'h0, 25'h0, 24'h0, 3'd3, 7'd29, 4'h8, 1'b0, 8'h5a, 180'd0}, 11);
    send_pdu({8'hff, 248'd0}, 1);
    send_pdu({8'h80, 248'd0}, 3);
    send_pdu({2'b01, 4'd2, 2'd0, 248'd0}, 10);
    send_pdu({2'b01, TYPE_EXT_LOC, 2'd3, 248'd0}, 10);
    send_pdu({2'b01, TYPE_EXT_LOC, 2'd0, 4'd11, 244'd0}, 10);
    send_pdu({2'b01, TYPE_EXT_LOC, 2'd0, 4'd15, 244'd0}, 10);
    for (int s = 0; s <= 10; s++) send_pdu(long_pdu(2'(s % 3), 4'(s), 3'(s)), 24);
    for (int v = 0; v < 8; v++) send_pdu(long_pdu(2'(v % 3), 4'd0, 3'(v)), 8);
    send_pdu({$urandom, 224'd0}, 1);
    while (bytes_sent < 1650) random_pdu();
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && bytes_sent > 600) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (1500) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    while (pending_reports != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
